>>> src/wit_pkg.sv
// ----------------------------------------------------------------------------
// wit_pkg: shared types and constants
// Sizes, register indexes and the tile word passed from the front end,
// through the queue, to the transform back end.
// ----------------------------------------------------------------------------
`default_nettype none
package wit_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int PIXEL_BITS   = 16;
  localparam int RES_BITS     = PIXEL_BITS + 2;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int CFG_W_BITS   = 11;
  localparam int CFG_H_BITS   = 13;
  localparam int CFG_IDX_BITS = 1;
  localparam int DIM_BITS     = 13;
  localparam int CMP_BITS     = DIM_BITS + 1;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int TILE_BITS    = 20;
  localparam int LINES        = 3;
  localparam int WIN          = 4;
  localparam int QDEPTH       = 2;
  localparam int QPTR_BITS    = $clog2(QDEPTH);
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = CFG_W_BITS'(226);
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = CFG_H_BITS'(226);

  typedef struct packed {
    logic [CFG_W_BITS-1:0] image_width;
    logic [CFG_H_BITS-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [WIN-1:0][WIN-1:0][PIXEL_BITS-1:0] d;
    logic [TILE_BITS-1:0]                    tile_index;
    logic                                    last_plane;
  } tile_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] hi);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (r < DIM_BITS'(WIN)) r = DIM_BITS'(WIN);
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic logic signed [PIXEL_BITS:0] sx1(input logic [PIXEL_BITS-1:0] v);
    return {v[PIXEL_BITS-1], v};
  endfunction

endpackage
`default_nettype wire

>>> src/wit_ram.sv
// ----------------------------------------------------------------------------
// wit_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wit_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/wit_front.sv
// ----------------------------------------------------------------------------
// wit_front: pixel intake, line stores and window assembly
// Tracks row and column, reads the column history from the line store and
// pushes each complete even-aligned 4x4 window to the tile queue.
// ----------------------------------------------------------------------------
`default_nettype none
module wit_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire wit_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [wit_pkg::PIXEL_BITS-1:0] in_pixel,
  output logic                              q_push,
  output wit_pkg::tile_t                    q_data,
  input  wire logic                         q_full
);

  localparam int PB = wit_pkg::PIXEL_BITS;
  localparam int CB = wit_pkg::CMP_BITS;

  logic [wit_pkg::DIM_BITS-1:0]  w_eff, h_eff;
  logic [wit_pkg::COL_BITS-1:0]  col_r, col_nxt, c_cur;
  logic [wit_pkg::ROW_BITS-1:0]  row_r, row_nxt, r_cur;
  logic [wit_pkg::TILE_BITS-1:0] tile_r, tile_nxt, t_cur;
  logic [CB-1:0]                 row_t, c_inc, r_inc;
  logic                          is_tile, last_plane, accept, b_adv;

  logic                          b_valid_r, b_valid_nxt;
  logic [wit_pkg::COL_BITS-1:0]  b_col_r;
  logic [PB-1:0]                 b_pix_r;
  logic                          b_tile_r, b_last_r;
  logic [wit_pkg::TILE_BITS-1:0] b_idx_r;

  logic [wit_pkg::LINES*PB-1:0]  ram_rd, ram_wr;
  logic [wit_pkg::WIN-1:0][PB-1:0]                colv;
  logic [wit_pkg::LINES-1:0][wit_pkg::WIN-1:0][PB-1:0] win_r;

  assign w_eff = wit_pkg::clamp_dim(wit_pkg::DIM_BITS'(cfg.image_width),
                                    wit_pkg::DIM_BITS'(wit_pkg::MAX_WIDTH));
  assign h_eff = wit_pkg::clamp_dim(wit_pkg::DIM_BITS'(cfg.image_height),
                                    wit_pkg::DIM_BITS'(wit_pkg::HEIGHT_LIMIT));

  assign b_adv    = !(b_tile_r && q_full);
  assign in_stall = b_valid_r && !b_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    c_cur = col_r;
    row_t = CB'(row_r);
    t_cur = tile_r;
    if (CB'(col_r) >= CB'(w_eff)) begin
      c_cur = '0;
      row_t = CB'(row_r) + CB'(1);
    end
    r_cur = wit_pkg::ROW_BITS'(row_t);
    if (row_t >= CB'(h_eff)) begin
      r_cur = '0;
      t_cur = '0;
    end

    is_tile = (r_cur >= wit_pkg::ROW_BITS'(3)) && (c_cur >= wit_pkg::COL_BITS'(3)) &&
              r_cur[0] && c_cur[0];
    last_plane = (CB'(r_cur) + CB'(2) >= CB'(h_eff)) &&
                 (CB'(c_cur) + CB'(2) >= CB'(w_eff));

    tile_nxt = is_tile ? t_cur + wit_pkg::TILE_BITS'(1) : t_cur;
    c_inc    = CB'(c_cur) + CB'(1);
    r_inc    = CB'(r_cur) + CB'(1);
    col_nxt  = wit_pkg::COL_BITS'(c_inc);
    row_nxt  = r_cur;
    if (c_inc >= CB'(w_eff)) begin
      col_nxt = '0;
      row_nxt = wit_pkg::ROW_BITS'(r_inc);
      if (r_inc >= CB'(h_eff)) begin
        row_nxt  = '0;
        tile_nxt = '0;
      end
    end
  end

  always_comb begin
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end else begin
      b_valid_nxt = b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      tile_r    <= '0;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        tile_r <= tile_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r  <= c_cur;
      b_pix_r  <= in_pixel;
      b_tile_r <= is_tile;
      b_idx_r  <= t_cur;
      b_last_r <= last_plane;
    end
  end

  wit_ram #(
    .WIDTH(wit_pkg::LINES * PB),
    .DEPTH(wit_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(c_cur),
    .rd_data(ram_rd),
    .wr_en  (b_valid_r && b_adv),
    .wr_addr(b_col_r),
    .wr_data(ram_wr)
  );

  // column of the window: three stored rows, oldest first, then this pixel
  assign colv[0] = ram_rd[0*PB +: PB];
  assign colv[1] = ram_rd[1*PB +: PB];
  assign colv[2] = ram_rd[2*PB +: PB];
  assign colv[3] = b_pix_r;
  assign ram_wr  = {colv[3], colv[2], colv[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (b_valid_r && b_adv) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= colv;
    end
  end

  always_comb begin
    for (int i = 0; i < wit_pkg::WIN; i++) begin
      for (int k = 0; k < wit_pkg::LINES; k++) begin
        q_data.d[i][k] = win_r[k][i];
      end
      q_data.d[i][wit_pkg::WIN-1] = colv[i];
    end
    q_data.tile_index = b_idx_r;
    q_data.last_plane = b_last_r;
  end

  assign q_push = b_valid_r && b_tile_r && !q_full;

endmodule
`default_nettype wire

>>> src/wit_queue.sv
// ----------------------------------------------------------------------------
// wit_queue: short tile queue
// Decouples window assembly from transform output.
// ----------------------------------------------------------------------------
`default_nettype none
module wit_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wit_pkg::tile_t push_data,
  output logic                full,
  input  wire logic           pop,
  output wit_pkg::tile_t      head,
  output logic                empty
);

  wit_pkg::tile_t                 mem_r [wit_pkg::QDEPTH];
  logic [wit_pkg::QPTR_BITS-1:0]  wp_r, rp_r;
  logic [wit_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == wit_pkg::QCNT_BITS'(wit_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + wit_pkg::QCNT_BITS'(1);
    if (pop && !push) cnt_nxt = cnt_r - wit_pkg::QCNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == wit_pkg::QPTR_BITS'(wit_pkg::QDEPTH - 1)) ? '0 :
                wp_r + wit_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == wit_pkg::QPTR_BITS'(wit_pkg::QDEPTH - 1)) ? '0 :
                rp_r + wit_pkg::QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> src/wit_back.sv
// ----------------------------------------------------------------------------
// wit_back: transform back end
// Produces one row of B^T d B per cycle from the queue head into the
// output register, while the queue has a tile and the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module wit_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire wit_pkg::tile_t                      head,
  input  wire logic                                empty,
  output logic                                     pop,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [wit_pkg::RES_BITS-1:0]      out_w0,
  output logic signed [wit_pkg::RES_BITS-1:0]      out_w1,
  output logic signed [wit_pkg::RES_BITS-1:0]      out_w2,
  output logic signed [wit_pkg::RES_BITS-1:0]      out_w3,
  output logic [1:0]                               out_tile_row,
  output logic [wit_pkg::TILE_BITS-1:0]            out_tile_index,
  output logic                                     out_last_of_tile,
  output logic                                     out_last_of_plane
);

  localparam int PB = wit_pkg::PIXEL_BITS;
  localparam int RB = wit_pkg::RES_BITS;

  logic [1:0]                row_r;
  logic                      load, last_row, out_valid_r;
  logic signed [PB:0]        t [wit_pkg::WIN];
  logic signed [RB-1:0]      t0, t1, t2, t3;
  logic signed [RB-1:0]      w0, w1, w2, w3;

  assign last_row = (row_r == 2'd3);
  assign load     = !empty && (!out_valid_r || !out_stall);
  assign pop      = load && last_row;
  assign out_valid = out_valid_r;

  always_comb begin
    for (int k = 0; k < wit_pkg::WIN; k++) begin
      case (row_r)
        2'd0:    t[k] = wit_pkg::sx1(head.d[0][k]) - wit_pkg::sx1(head.d[2][k]);
        2'd1:    t[k] = wit_pkg::sx1(head.d[1][k]) + wit_pkg::sx1(head.d[2][k]);
        2'd2:    t[k] = wit_pkg::sx1(head.d[2][k]) - wit_pkg::sx1(head.d[1][k]);
        default: t[k] = wit_pkg::sx1(head.d[1][k]) - wit_pkg::sx1(head.d[3][k]);
      endcase
    end
    t0 = {t[0][PB], t[0]};
    t1 = {t[1][PB], t[1]};
    t2 = {t[2][PB], t[2]};
    t3 = {t[3][PB], t[3]};
    w0 = t0 - t2;
    w1 = t1 + t2;
    w2 = t2 - t1;
    w3 = t1 - t3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load || (out_valid_r && out_stall);
      if (load) begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_w0            <= w0;
      out_w1            <= w1;
      out_w2            <= w2;
      out_w3            <= w3;
      out_tile_row      <= row_r;
      out_tile_index    <= head.tile_index;
      out_last_of_tile  <= last_row;
      out_last_of_plane <= last_row && head.last_plane;
    end
  end

endmodule
`default_nettype wire

>>> src/winograd_input_tile_transform.sv
// Path: a tile-completing pixel is registered in the front end's buffer, pushed into the
// tile queue and loaded from its head into the output register; the other three rows
// follow one per cycle while out_stall is low. Throughput: one pixel per cycle while the
// two-entry tile queue has room; four output words per tile can stall odd rows.
// Reset: synchronous active-low; counters, window and queue clear, registers
// return to 226 by 226. The line store is not cleared.
// ----------------------------------------------------------------------------
// winograd_input_tile_transform: F(2x2,3x3) input tile transform
// Raster pixel stream in, transformed 4x4 tiles out one row per word.
// ----------------------------------------------------------------------------
`default_nettype none
module winograd_input_tile_transform (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [wit_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [wit_pkg::CFG_H_BITS-1:0]       cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [wit_pkg::PIXEL_BITS-1:0] in_pixel,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [wit_pkg::RES_BITS-1:0]       out_w0,
  output logic signed [wit_pkg::RES_BITS-1:0]       out_w1,
  output logic signed [wit_pkg::RES_BITS-1:0]       out_w2,
  output logic signed [wit_pkg::RES_BITS-1:0]       out_w3,
  output logic [1:0]                                out_tile_row,
  output logic [wit_pkg::TILE_BITS-1:0]             out_tile_index,
  output logic                                      out_last_of_tile,
  output logic                                      out_last_of_plane
);

  wit_pkg::cfg_t  cfg_r;
  wit_pkg::tile_t q_in, q_head;
  logic           q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= wit_pkg::WIDTH_RESET;
      cfg_r.image_height <= wit_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wit_pkg::CFG_IMAGE_WIDTH:
          cfg_r.image_width <= cfg_wdata[wit_pkg::CFG_W_BITS-1:0];
        wit_pkg::CFG_IMAGE_HEIGHT:
          cfg_r.image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wit_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pixel(in_pixel),
    .q_push  (q_push),
    .q_data  (q_in),
    .q_full  (q_full)
  );

  wit_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  wit_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .empty            (q_empty),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_w0           (out_w0),
    .out_w1           (out_w1),
    .out_w2           (out_w2),
    .out_w3           (out_w3),
    .out_tile_row     (out_tile_row),
    .out_tile_index   (out_tile_index),
    .out_last_of_tile (out_last_of_tile),
    .out_last_of_plane(out_last_of_plane)
  );

endmodule
`default_nettype wire
